// ===== sv/olst_pkg.sv =====
// ----------------------------------------------------------------------------
// olst_pkg
// Shared types and constants for the ordered list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package olst_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 4;
  localparam int VAL_W = 32;

  typedef enum logic [3:0] {
    OP_INS_FRONT  = 4'd0,
    OP_INS_END    = 4'd1,
    OP_INS_SORTED = 4'd2,
    OP_DEL_FRONT  = 4'd3,
    OP_DEL_END    = 4'd4,
    OP_DEL_VALUE  = 4'd5,
    OP_DEL_POS    = 4'd6,
    OP_CLEAR      = 4'd7,
    OP_READ       = 4'd8
  } olst_op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADPOS   = 3'd4
  } olst_status_t;

  typedef struct packed {
    logic [3:0]              cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } olst_req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] data;
  } olst_rsp_t;

  typedef struct packed {
    olst_op_t                op;
    logic [CNT_W-1:0]        count;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } olst_ctl_t;

  typedef struct packed {
    logic do_ins;
    logic do_del;
  } olst_cmt_t;

endpackage

`default_nettype wire

// ===== sv/olst_cell.sv =====
// ----------------------------------------------------------------------------
// olst_cell
// One storage cell of the list: holds an entry, finds the first target in
// the chain and shifts toward or away from its neighbors on commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module olst_cell import olst_pkg::*; (
  input  logic                    clk,
  input  logic [CNT_W-1:0]        idx,
  input  olst_ctl_t               ctl,
  input  olst_cmt_t               cmt,
  input  logic signed [VAL_W-1:0] left,
  input  logic signed [VAL_W-1:0] right,
  input  logic                    hit_in,
  output logic                    hit_out,
  input  logic signed [VAL_W-1:0] data_in,
  output logic signed [VAL_W-1:0] data_out,
  output logic signed [VAL_W-1:0] entry
);

  logic                    match;
  logic                    tgt;
  logic                    live;
  logic signed [VAL_W-1:0] entry_next;

  assign live = idx < ctl.count;

  always_comb begin
    case (ctl.op)
      OP_INS_FRONT:  match = (idx == '0);
      OP_INS_END:    match = (idx == ctl.count);
      OP_INS_SORTED: match = (live && (ctl.value < entry)) || (idx == ctl.count);
      OP_DEL_FRONT:  match = (idx == '0);
      OP_DEL_END:    match = ((idx + CNT_W'(1)) == ctl.count);
      OP_DEL_VALUE:  match = live && (entry == ctl.value);
      OP_DEL_POS:    match = (idx == CNT_W'(ctl.position));
      OP_READ:       match = (idx == CNT_W'(ctl.position));
      default:       match = 1'b0;
    endcase
  end

  assign tgt      = match && !hit_in;
  assign hit_out  = match || hit_in;
  assign data_out = tgt ? entry : data_in;

  always_comb begin
    entry_next = entry;
    if (cmt.do_ins) begin
      if (tgt) begin
        entry_next = ctl.value;
      end else if (hit_in) begin
        entry_next = left;
      end
    end else if (cmt.do_del && hit_out) begin
      entry_next = right;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== sv/ordered_list_store.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store
// Bounded ordered store of signed 32-bit entries built as a chain of cells.
// ----------------------------------------------------------------------------
//   channel  signals                      direction  payload
//   req      req_valid, req_ready, req    into block olst_req_t (cmd, value, position)
//   rsp      rsp_valid, rsp_ready, rsp    out of     olst_rsp_t (status, count, data)
//
//   Each command is decoded and committed at the transfer; its result sits in
//   the output register the cycle after the transfer. The path is the match
//   chain through all DEPTH cells. A new command is taken whenever the output
//   register is empty or drains in the same cycle. Reset clears the count and
//   the output valid; entry contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_store import olst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  olst_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output olst_rsp_t rsp
);

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    accept;
  olst_ctl_t               ctl;
  olst_cmt_t               cmt;
  olst_op_t                op;
  logic                    hit  [DEPTH+1];
  logic signed [VAL_W-1:0] dat  [DEPTH+1];
  logic signed [VAL_W-1:0] ent  [DEPTH];
  logic                    full;
  logic                    empty;
  logic                    found;
  logic                    pos_ok;
  olst_status_t            status;
  logic                    emit_data;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign op        = olst_op_t'(req.cmd);

  assign ctl.op       = op;
  assign ctl.count    = count;
  assign ctl.position = req.position;
  assign ctl.value    = req.value;

  assign hit[0] = 1'b0;
  assign dat[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_nb;
    logic signed [VAL_W-1:0] right_nb;
    if (i == 0) begin : g_first
      assign left_nb = req.value;
    end else begin : g_mid
      assign left_nb = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_nb = ent[i];
    end else begin : g_inner
      assign right_nb = ent[i+1];
    end
    olst_cell u_cell (
      .clk      (clk),
      .idx      (CNT_W'(i)),
      .ctl      (ctl),
      .cmt      (cmt),
      .left     (left_nb),
      .right    (right_nb),
      .hit_in   (hit[i]),
      .hit_out  (hit[i+1]),
      .data_in  (dat[i]),
      .data_out (dat[i+1]),
      .entry    (ent[i])
    );
  end

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign found  = hit[DEPTH];
  assign pos_ok = CNT_W'(req.position) < count;

  always_comb begin
    status     = ST_OK;
    cmt.do_ins = 1'b0;
    cmt.do_del = 1'b0;
    emit_data  = 1'b0;
    count_next = count;
    case (op)
      OP_INS_FRONT, OP_INS_END, OP_INS_SORTED: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmt.do_ins = accept;
          count_next = count + CNT_W'(1);
        end
      end
      OP_DEL_FRONT, OP_DEL_END, OP_DEL_VALUE, OP_DEL_POS, OP_READ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (op == OP_DEL_VALUE && !found) begin
          status = ST_NOTFOUND;
        end else if ((op == OP_DEL_POS || op == OP_READ) && !pos_ok) begin
          status = ST_BADPOS;
        end else begin
          emit_data = 1'b1;
          if (op != OP_READ) begin
            cmt.do_del = accept;
            count_next = count - CNT_W'(1);
          end
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status <= status;
      rsp.count  <= count_next;
      rsp.data   <= emit_data ? dat[DEPTH] : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_rsp_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("no result after transfer");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |-> rsp.count == CNT_W'(DEPTH))
    else $error("full status with count below depth");

  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> rsp.data == '0)
    else $error("data on failed command");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.count == count)
    else $error("result count differs from held count");

endmodule

`default_nettype wire

// ===== tb/sv/ordered_list_store_tb.sv =====
// ----------------------------------------------------------------------------
// ordered_list_store_tb
// Self-checking bench for the ordered list store. A directed pass walks the
// empty, head, tail, not-found and bad-position cases, then random command
// runs push the store between empty and full. A shadow list predicts every
// response. Both handshakes idle at random, and one long receiver stall
// backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_store_tb;
  import olst_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_LINES   = 40;
  localparam logic [3:0] CMD_SPARE_LO = 4'(OP_READ) + 4'd1;
  localparam logic [3:0] CMD_SPARE_HI = 4'hF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  olst_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  olst_rsp_t rsp;

  olst_req_t pending_cmds[$];
  olst_rsp_t owed_results[$];
  logic signed [VAL_W-1:0] recent_vals[$];

  logic signed [VAL_W-1:0] shadow_list[DEPTH];
  int shadow_count = 0;

  int n_queued = 0;
  int n_accepted = 0;
  int n_errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  ordered_list_store u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic signed [VAL_W-1:0] take_entry(input int idx);
    logic signed [VAL_W-1:0] v;
    int i;
    v = shadow_list[idx];
    for (i = idx; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
    return v;
  endfunction

  function automatic olst_rsp_t apply_command(input olst_req_t r);
    olst_rsp_t res;
    int idx;
    int i;
    res.status = ST_OK;
    res.data   = '0;
    case (r.cmd)
      OP_INS_FRONT, OP_INS_END, OP_INS_SORTED: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (r.cmd == OP_INS_FRONT) begin
            idx = 0;
          end else if (r.cmd == OP_INS_END) begin
            idx = shadow_count;
          end else begin
            idx = 0;
            while (idx < shadow_count && !(r.value < shadow_list[idx])) idx++;
          end
          for (i = shadow_count; i > idx; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[idx] = r.value;
          shadow_count++;
        end
      end
      OP_DEL_FRONT, OP_DEL_END, OP_DEL_VALUE, OP_DEL_POS, OP_READ: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (r.cmd == OP_DEL_FRONT) begin
          res.data = take_entry(0);
        end else if (r.cmd == OP_DEL_END) begin
          res.data = take_entry(shadow_count - 1);
        end else if (r.cmd == OP_DEL_VALUE) begin
          idx = 0;
          while (idx < shadow_count && shadow_list[idx] != r.value) idx++;
          if (idx < shadow_count) res.data = take_entry(idx);
          else res.status = ST_NOTFOUND;
        end else if (int'(r.position) >= shadow_count) begin
          res.status = ST_BADPOS;
        end else if (r.cmd == OP_DEL_POS) begin
          res.data = take_entry(int'(r.position));
        end else begin
          res.data = shadow_list[r.position];
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    res.count = CNT_W'(shadow_count);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (n_errors < MAX_LINES)
      $display("mismatch %s at %0t: got %0d want %0d", field, $realtime, got, want);
    n_errors++;
  endtask

  task automatic queue_cmd(input logic [3:0] cmd, input logic signed [VAL_W-1:0] v,
                           input logic [POS_W-1:0] p);
    olst_req_t r;
    r.cmd      = cmd;
    r.value    = v;
    r.position = p;
    pending_cmds.push_back(r);
    n_queued++;
    if (cmd == OP_INS_FRONT || cmd == OP_INS_END || cmd == OP_INS_SORTED) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > DEPTH) void'(recent_vals.pop_front());
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 30) return VAL_W'(int'($urandom_range(8)) - 4);
    if (r < 40) return ($urandom_range(1) != 0) ? VAL_MAX : VAL_MIN;
    if (r < 65 && recent_vals.size() > 0)
      return recent_vals[$urandom_range(recent_vals.size() - 1)];
    return $urandom;
  endfunction

  // Runs of commands lean toward filling or draining so the count swings
  // between empty and full.
  task automatic queue_random(input int n);
    int ins_pct;
    int r;
    int k;
    logic [3:0] cmd;
    ins_pct = 50;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: ins_pct = 80;
          1: ins_pct = 50;
          default: ins_pct = 20;
        endcase
      end
      r = $urandom_range(99);
      if (r < 2) begin
        cmd = 4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      end else if (r < 3) begin
        cmd = OP_CLEAR;
      end else if (r < 3 + ins_pct) begin
        case ($urandom_range(2))
          0: cmd = OP_INS_FRONT;
          1: cmd = OP_INS_END;
          default: cmd = OP_INS_SORTED;
        endcase
      end else begin
        case ($urandom_range(4))
          0: cmd = OP_DEL_FRONT;
          1: cmd = OP_DEL_END;
          2: cmd = OP_DEL_VALUE;
          3: cmd = OP_DEL_POS;
          default: cmd = OP_READ;
        endcase
      end
      queue_cmd(cmd, pick_value(), POS_W'($urandom_range(DEPTH - 1)));
    end
  endtask

  task automatic drain_all();
    while (n_accepted != n_queued) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        owed_results.push_back(apply_command(req));
        n_accepted++;
      end
      if (!req_valid || req_ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req       <= pending_cmds.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    olst_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unowed result", rsp.data, 0);
        end else begin
          want = owed_results.pop_front();
          if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
          if (rsp.count !== want.count) report_mismatch("count", rsp.count, want.count);
          if (rsp.data !== want.data) report_mismatch("data", rsp.data, want.data);
        end
      end
      if (hold_req && !hold_done) begin
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct <= 17;
    recv_idle_pct <= 62;

    // empty store: every delete and read flags empty
    queue_cmd(OP_READ, 0, 0);
    queue_cmd(OP_DEL_FRONT, 0, 0);
    queue_cmd(OP_DEL_END, 0, 0);
    queue_cmd(OP_DEL_VALUE, 0, 0);
    queue_cmd(OP_DEL_POS, 0, 0);
    // sorted placement across the signed extremes
    queue_cmd(OP_INS_SORTED, 0, 0);
    queue_cmd(OP_INS_SORTED, VAL_MAX, 0);
    queue_cmd(OP_INS_SORTED, VAL_MIN, 0);
    queue_cmd(OP_INS_SORTED, -1, 0);
    queue_cmd(OP_INS_FRONT, 5, 0);
    queue_cmd(OP_INS_END, -7, 0);
    queue_cmd(OP_READ, 0, 4'hF);
    queue_cmd(OP_READ, 0, 4'd5);
    queue_cmd(OP_DEL_VALUE, 12345, 0);
    queue_cmd(OP_DEL_VALUE, 5, 0);
    queue_cmd(OP_DEL_POS, 0, 4'd0);
    queue_cmd(OP_DEL_POS, 0, 4'd3);
    queue_cmd(OP_DEL_FRONT, 0, 0);
    queue_cmd(OP_DEL_END, 0, 0);
    queue_cmd(CMD_SPARE_HI, VAL_MIN, 4'hF);
    queue_cmd(CMD_SPARE_LO, VAL_MAX, 4'h0);
    queue_cmd(OP_CLEAR, 0, 0);
    queue_cmd(OP_INS_END, VAL_MAX, 0);
    queue_cmd(OP_READ, 0, 4'd0);
    queue_random(520);
    drain_all();

    send_idle_pct <= 62;
    recv_idle_pct <= 17;
    queue_random(520);
    drain_all();

    // hold off the receiver while the sender keeps offering
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_req      <= 1'b1;
    queue_random(500);
    drain_all();

    repeat (10) @(posedge clk);
    if (n_errors == 0 && owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
